/* design/msr_pkg.sv */
// Shared types and constants of the matrix shell rotate block.
package msr_pkg;

	// Input item of the data channel
	typedef struct packed {
		logic               func;
		logic [4:0]         row;
		logic [4:0]         col;
		logic signed [31:0] value;
	} msr_in_t;

	// Result item of the data channel
	typedef struct packed {
		logic signed [31:0] read_value;
		logic               on_ring;
		logic               shell_invalid;
	} msr_out_t;

	// Operation codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// Configuration register map
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_NUM_ROWS     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NUM_COLS     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHELL_NUMBER = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROTATE_BY    = 2'd3;

	// Register reset values
	localparam logic [5:0]  NUM_ROWS_RST     = 6'd32;
	localparam logic [5:0]  NUM_COLS_RST     = 6'd32;
	localparam logic [4:0]  SHELL_NUMBER_RST = 5'd1;
	localparam logic [15:0] ROTATE_BY_RST    = 16'd0;

	// Rotation amount width and its bit counter
	localparam int ROT_W     = 16;
	localparam int ROT_CNT_W = 4;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_WRAP,
		ST_MAP,
		ST_READ,
		ST_DONE
	} msr_state_t;

endpackage

/* design/matrix_shell_rotate_core.sv */
// Matrix store with rotated-shell reads: sequencer, remainder unit and address mapping.
//
// One item is handled at a time; in_ready is high only while the block is idle, and a
// finished result waits in the output register so the next item can be taken meanwhile.
// A write, or an access outside the store, goes from transfer straight to loading its
// result. A read of a position off the selected ring reads the RAM, then loads the
// result. A read of a ring position first reduces the rotation amount modulo the ring
// length by a restoring remainder unit, one bit of rotate_by per cycle, followed by one
// step each to wrap the ring index, map it back to row and column, read the RAM and
// load the result. A result that cannot enter a still-full output register holds the
// block in its last state until the waiting result leaves. The store is a
// MAX_DIM x MAX_DIM RAM with no clearing pass; an entry never written reads as whatever
// the RAM holds.
module matrix_shell_rotate_core #(
	parameter int MAX_DIM    = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [msr_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [msr_pkg::CFG_DATA_W-1:0]        cfg_data,
	// input item channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  msr_pkg::msr_in_t                      in_data,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output msr_pkg::msr_out_t                     out_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [8:0] MAX_DIM_V = 9'(MAX_DIM);

	// Configuration registers
	logic [5:0]                  num_rows_q;
	logic [5:0]                  num_cols_q;
	logic [4:0]                  shell_q;
	logic [msr_pkg::ROT_W-1:0]   rot_q;

	// Sequencer
	msr_pkg::msr_state_t         state_q, state_d;
	logic                        in_xfer;
	logic                        ram_re;
	logic                        load_out;

	// Item context
	logic                        func_q;
	logic                        in_store_q;
	logic                        ring_q;
	logic                        invalid_q;
	logic [7:0]                  k_q;
	logic [7:0]                  len_q;
	logic [5:0]                  h_q;
	logic [5:0]                  w_q;
	logic [4:0]                  top_q;
	logic [5:0]                  bot_q;
	logic [5:0]                  right_q;
	logic [5:0]                  sr_q;
	logic [5:0]                  sc_q;
	logic [7:0]                  rem_q;
	logic [7:0]                  j_q;
	logic [msr_pkg::ROT_CNT_W-1:0] bit_cnt_q;

	// Output register
	logic                        out_valid_q;
	msr_pkg::msr_out_t           out_q;
	msr_pkg::msr_out_t           out_d;

	// Geometry of the selected shell
	logic [5:0]                  rows_eff;
	logic [5:0]                  cols_eff;
	logic signed [8:0]           s_v, top_v, bot_v, right_v, h_v, w_v, len_v;
	logic signed [8:0]           row_v, col_v, k_v;
	logic                        invalid_v;
	logic                        ring_v;
	logic                        in_store_v;

	// Remainder, wrap and map datapath
	logic [8:0]                  div_trial;
	logic [8:0]                  wrap_sum;
	logic [8:0]                  jv, hv, wv, topv, botv, rightv;
	logic [8:0]                  sr_d, sc_d;

	// RAM ports
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [AW-1:0]               ram_raddr;
	logic [DATA_WIDTH-1:0]       ram_wdata;
	logic [DATA_WIDTH-1:0]       ram_rdata;

	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= msr_pkg::NUM_ROWS_RST;
			num_cols_q <= msr_pkg::NUM_COLS_RST;
			shell_q    <= msr_pkg::SHELL_NUMBER_RST;
			rot_q      <= msr_pkg::ROTATE_BY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				msr_pkg::CFG_NUM_ROWS:     num_rows_q <= cfg_data[5:0];
				msr_pkg::CFG_NUM_COLS:     num_cols_q <= cfg_data[5:0];
				msr_pkg::CFG_SHELL_NUMBER: shell_q    <= cfg_data[4:0];
				msr_pkg::CFG_ROTATE_BY:    rot_q      <= cfg_data;
				default:                   rot_q      <= rot_q;
			endcase
		end
	end

	// Clamp dimensions and derive the shell bounds
	always_comb begin
		rows_eff  = (9'(num_rows_q) > MAX_DIM_V) ? MAX_DIM_V[5:0] : num_rows_q;
		cols_eff  = (9'(num_cols_q) > MAX_DIM_V) ? MAX_DIM_V[5:0] : num_cols_q;
		s_v       = $signed({4'b0, shell_q});
		top_v     = s_v - 9'sd1;
		bot_v     = $signed({3'b0, rows_eff}) - s_v;
		right_v   = $signed({3'b0, cols_eff}) - s_v;
		h_v       = bot_v - top_v + 9'sd1;
		w_v       = right_v - top_v + 9'sd1;
		len_v     = 9'sd2 * h_v + 9'sd2 * w_v - 9'sd4;
		invalid_v = (shell_q == 5'd0) || (h_v < 9'sd2) || (w_v < 9'sd2);
	end

	// Locate the addressed position on the ring
	always_comb begin
		row_v      = $signed({4'b0, in_data.row});
		col_v      = $signed({4'b0, in_data.col});
		in_store_v = (9'(in_data.row) < MAX_DIM_V) && (9'(in_data.col) < MAX_DIM_V);
		ring_v     = 1'b0;
		k_v        = 9'sd0;
		if (!invalid_v) begin
			if (col_v == top_v && row_v >= top_v && row_v <= bot_v) begin
				ring_v = 1'b1;
				k_v    = row_v - top_v;
			end else if (row_v == bot_v && col_v > top_v && col_v <= right_v) begin
				ring_v = 1'b1;
				k_v    = h_v - 9'sd1 + (col_v - top_v);
			end else if (col_v == right_v && row_v >= top_v && row_v < bot_v) begin
				ring_v = 1'b1;
				k_v    = h_v + w_v - 9'sd2 + (bot_v - row_v);
			end else if (row_v == top_v && col_v > top_v && col_v < right_v) begin
				ring_v = 1'b1;
				k_v    = 9'sd2 * h_v + w_v - 9'sd3 + (right_v - col_v);
			end
		end
	end

	// One restoring remainder step and the wrap of the rotated index
	always_comb begin
		div_trial = {rem_q, rot_q[bit_cnt_q]};
		wrap_sum  = {1'b0, k_q} + {1'b0, rem_q};
	end

	// Map the rotated ring index back to row and column
	always_comb begin
		jv     = {1'b0, j_q};
		hv     = {3'b0, h_q};
		wv     = {3'b0, w_q};
		topv   = {4'b0, top_q};
		botv   = {3'b0, bot_q};
		rightv = {3'b0, right_q};
		if (jv < hv) begin
			sr_d = topv + jv;
			sc_d = topv;
		end else if (jv < hv + wv - 9'd1) begin
			sr_d = botv;
			sc_d = topv + jv - hv + 9'd1;
		end else if (jv < 9'd2 * hv + wv - 9'd2) begin
			sr_d = botv - (jv - (hv + wv - 9'd2));
			sc_d = rightv;
		end else begin
			sr_d = topv;
			sc_d = rightv - (jv - (9'd2 * hv + wv - 9'd3));
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ram_re   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			msr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_data.func == msr_pkg::FUNC_WRITE || !in_store_v) begin
						state_d = msr_pkg::ST_DONE;
					end else if (ring_v) begin
						state_d = msr_pkg::ST_DIV;
					end else begin
						state_d = msr_pkg::ST_READ;
					end
				end
			end
			msr_pkg::ST_DIV: begin
				if (bit_cnt_q == '0) begin
					state_d = msr_pkg::ST_WRAP;
				end
			end
			msr_pkg::ST_WRAP: begin
				state_d = msr_pkg::ST_MAP;
			end
			msr_pkg::ST_MAP: begin
				state_d = msr_pkg::ST_READ;
			end
			msr_pkg::ST_READ: begin
				ram_re  = 1'b1;
				state_d = msr_pkg::ST_DONE;
			end
			msr_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = msr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = msr_pkg::ST_IDLE;
			end
		endcase
	end

	// Item context: capture on transfer, then step the remainder, wrap and map
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q     <= in_data.func;
			in_store_q <= in_store_v;
			ring_q     <= ring_v && in_store_v;
			invalid_q  <= invalid_v;
			k_q        <= k_v[7:0];
			len_q      <= len_v[7:0];
			h_q        <= h_v[5:0];
			w_q        <= w_v[5:0];
			top_q      <= top_v[4:0];
			bot_q      <= bot_v[5:0];
			right_q    <= right_v[5:0];
			sr_q       <= {1'b0, in_data.row};
			sc_q       <= {1'b0, in_data.col};
			rem_q      <= '0;
			bit_cnt_q  <= msr_pkg::ROT_CNT_W'(msr_pkg::ROT_W - 1);
		end else begin
			case (state_q)
				msr_pkg::ST_DIV: begin
					rem_q     <= (div_trial >= {1'b0, len_q})
					             ? 8'(div_trial - {1'b0, len_q}) : div_trial[7:0];
					bit_cnt_q <= bit_cnt_q - 1'b1;
				end
				msr_pkg::ST_WRAP: begin
					j_q <= (wrap_sum >= {1'b0, len_q}) ? 8'(wrap_sum - {1'b0, len_q})
					                                  : wrap_sum[7:0];
				end
				msr_pkg::ST_MAP: begin
					sr_q <= sr_d[5:0];
					sc_q <= sc_d[5:0];
				end
				default: begin
					rem_q <= rem_q;
				end
			endcase
		end
	end

	// Store port addressing
	assign ram_we    = in_xfer && (in_data.func == msr_pkg::FUNC_WRITE) && in_store_v;
	assign ram_waddr = AW'(int'(in_data.row) * MAX_DIM + int'(in_data.col));
	assign ram_wdata = DATA_WIDTH'(in_data.value);
	assign ram_raddr = AW'(int'(sr_q) * MAX_DIM + int'(sc_q));

	msr_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Build the result: zero on a write or outside the store
	always_comb begin
		out_d.read_value    = 32'sd0;
		if (func_q == msr_pkg::FUNC_READ && in_store_q) begin
			out_d.read_value = 32'($signed(ram_rdata));
		end
		out_d.on_ring       = ring_q;
		out_d.shell_invalid = invalid_q;
	end

	// Output register: hold until the result transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* design/msr_ram.sv */
// Generic simple dual-port RAM with registered read.
module msr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/msr_checker.sv */
// Port-level assertions for the matrix shell rotate core, bound to the top level.
module msr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input msr_pkg::msr_out_t               out_data
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// After an input transfer the block is not ready in the next cycle
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// A new result only appears after the block has been busy
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without work");

	// A degenerate shell never reports a ring position
	a_invalid_off_ring: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.shell_invalid |-> !out_data.on_ring)
		else $error("ring position on degenerate shell");

endmodule

bind matrix_shell_rotate_core msr_checker u_msr_checker (.*);

/* tb/tb_matrix_shell_rotate_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the matrix shell rotate core with a rotation tracker class.
module tb_matrix_shell_rotate_core;

	localparam int DIM         = 32;
	localparam int LIMIT       = 1000000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE      = 24;
	localparam int PHASES      = 14;
	localparam int PHASE_ITEMS = 70;

	// Track the matrix, the register settings and the results still owed by the core
	class shell_rotation_tracker;
		logic [31:0]        words [DIM*DIM];
		bit                 written [DIM*DIM];
		logic [5:0]         rows_reg;
		logic [5:0]         cols_reg;
		logic [4:0]         shell_reg;
		logic [15:0]        rot_reg;
		msr_pkg::msr_out_t  pending_results [$];
		int                 errors;
		int                 ring_reads;
		int                 flagged;

		function new();
			rows_reg   = msr_pkg::NUM_ROWS_RST;
			cols_reg   = msr_pkg::NUM_COLS_RST;
			shell_reg  = msr_pkg::SHELL_NUMBER_RST;
			rot_reg    = msr_pkg::ROTATE_BY_RST;
			errors     = 0;
			ring_reads = 0;
			flagged    = 0;
			foreach (written[i]) written[i] = 1'b0;
		endfunction

		function void set_reg(input logic [msr_pkg::CFG_INDEX_W-1:0] idx,
				input logic [msr_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				msr_pkg::CFG_NUM_ROWS:     rows_reg  = data[5:0];
				msr_pkg::CFG_NUM_COLS:     cols_reg  = data[5:0];
				msr_pkg::CFG_SHELL_NUMBER: shell_reg = data[4:0];
				msr_pkg::CFG_ROTATE_BY:    rot_reg   = data;
				default:                   rot_reg   = rot_reg;
			endcase
		endfunction

		// Bounds of the selected shell; left column equals the top row index
		function void geometry(output int top, output int bottom, output int right,
				output int h, output int w, output bit bad);
			int s;
			int nr;
			int nc;
			s      = shell_reg;
			nr     = (rows_reg > DIM) ? DIM : rows_reg;
			nc     = (cols_reg > DIM) ? DIM : cols_reg;
			top    = s - 1;
			bottom = nr - s;
			right  = nc - s;
			h      = bottom - top + 1;
			w      = right - top + 1;
			bad    = (s < 1) || (h < 2) || (w < 2);
		endfunction

		function int ring_len();
			int top, bottom, right, h, w;
			bit bad;
			geometry(top, bottom, right, h, w, bad);
			return bad ? 0 : 2 * h + 2 * w - 4;
		endfunction

		// Map a ring index back to row and column: down left, along bottom, up right, back top
		function void ring_pos(input int j, output int r, output int c);
			int top, bottom, right, h, w;
			bit bad;
			geometry(top, bottom, right, h, w, bad);
			if (j < h) begin
				r = top + j;
				c = top;
			end else if (j < h + w - 1) begin
				r = bottom;
				c = top + j - (h - 1);
			end else if (j < 2 * h + w - 2) begin
				r = bottom - (j - (h + w - 2));
				c = right;
			end else begin
				r = top;
				c = right - (j - (2 * h + w - 3));
			end
		endfunction

		// Find the store entry a read of (row, col) returns after the rotation
		function void locate(input logic [4:0] row, input logic [4:0] col,
				output int src, output bit ring, output bit bad);
			int top, bottom, right, h, w, rw, cl, k, len, j, sr, sc;
			geometry(top, bottom, right, h, w, bad);
			rw   = row;
			cl   = col;
			ring = 1'b0;
			k    = 0;
			if (!bad) begin
				if (cl == top && rw >= top && rw <= bottom) begin
					ring = 1'b1;
					k    = rw - top;
				end else if (rw == bottom && cl > top && cl <= right) begin
					ring = 1'b1;
					k    = h - 1 + cl - top;
				end else if (cl == right && rw >= top && rw < bottom) begin
					ring = 1'b1;
					k    = h + w - 2 + bottom - rw;
				end else if (rw == top && cl > top && cl < right) begin
					ring = 1'b1;
					k    = 2 * h + w - 3 + right - cl;
				end
			end
			src = rw * DIM + cl;
			if (ring) begin
				len = 2 * h + 2 * w - 4;
				j   = (k + int'(rot_reg) % len) % len;
				ring_pos(j, sr, sc);
				src = sr * DIM + sc;
			end
		endfunction

		// Apply an accepted input transfer and queue the result it owes
		function void note_transfer(input msr_pkg::msr_in_t item);
			msr_pkg::msr_out_t res;
			int                src;
			int                addr;
			bit                ring;
			bit                bad;
			locate(item.row, item.col, src, ring, bad);
			res.read_value    = '0;
			res.on_ring       = ring;
			res.shell_invalid = bad;
			if (item.func == msr_pkg::FUNC_WRITE) begin
				addr          = int'(item.row) * DIM + int'(item.col);
				words[addr]   = item.value;
				written[addr] = 1'b1;
			end else begin
				res.read_value = words[src];
				if (ring) ring_reads++;
			end
			if (bad) flagged++;
			pending_results = {pending_results, res};
		endfunction

		// Compare a result transfer with the oldest owed result
		function void check_transfer(input msr_pkg::msr_out_t got);
			msr_pkg::msr_out_t want;
			string             msg;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result read_value %0d on_ring %0b %s %0b",
						$time, got.read_value, got.on_ring, "shell_invalid",
						got.shell_invalid);
				return;
			end
			want = pending_results.pop_front();
			if (got.read_value !== want.read_value || got.on_ring !== want.on_ring ||
					got.shell_invalid !== want.shell_invalid) begin
				errors++;
				if (errors <= 10) begin
					msg = $sformatf("read_value exp %0d got %0d",
						want.read_value, got.read_value);
					msg = {msg, $sformatf(", on_ring exp %0b got %0b",
						want.on_ring, got.on_ring)};
					msg = {msg, $sformatf(", shell_invalid exp %0b got %0b",
						want.shell_invalid, got.shell_invalid)};
					$display("%0t: mismatch %s", $time, msg);
				end
			end
		endfunction
	endclass

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [msr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [msr_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	msr_pkg::msr_in_t                in_data   = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	msr_pkg::msr_out_t               out_data;

	shell_rotation_tracker tracker = new();
	bit calm     = 1'b0;
	bit hold_off = 1'b0;
	int cycles   = 0;
	int sent     = 0;
	int settings = 0;

	matrix_shell_rotate_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int roll;
		if (calm) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [5:0] pick_dim();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return 6'($urandom_range(2, 32));
		if (roll < 85) return 6'($urandom_range(33, 63));
		return 6'($urandom_range(0, 1));
	endfunction

	// Fill the unused upper data bits with junk half of the time
	function automatic logic [msr_pkg::CFG_DATA_W-1:0] pad_field(
			input logic [msr_pkg::CFG_DATA_W-1:0] v, input int width);
		if ($urandom_range(0, 1) == 0) return v;
		return v | (msr_pkg::CFG_DATA_W'($urandom()) << width);
	endfunction

	// Offer one input transfer after a random gap; valid stays high on return
	task automatic send_item(input msr_pkg::msr_in_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_transfer(item);
		sent++;
	endtask

	task automatic issue_write(input int row, input int col, input logic [31:0] word);
		msr_pkg::msr_in_t item;
		item.func  = msr_pkg::FUNC_WRITE;
		item.row   = 5'(row);
		item.col   = 5'(col);
		item.value = word;
		send_item(item);
	endtask

	// Read one element; write its rotated source first if it was never written
	task automatic issue_read(input int row, input int col);
		msr_pkg::msr_in_t item;
		int               src;
		bit               ring;
		bit               bad;
		tracker.locate(5'(row), 5'(col), src, ring, bad);
		if (!tracker.written[src]) issue_write(src / DIM, src % DIM, random_word());
		item.func  = msr_pkg::FUNC_READ;
		item.row   = 5'(row);
		item.col   = 5'(col);
		item.value = $urandom();
		send_item(item);
	endtask

	task automatic write_reg(input logic [msr_pkg::CFG_INDEX_W-1:0] idx,
			input logic [msr_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	task automatic set_config(input logic [5:0] rows, input logic [5:0] cols,
			input logic [4:0] shell, input logic [15:0] rot);
		write_reg(msr_pkg::CFG_NUM_ROWS, pad_field({10'd0, rows}, 6));
		write_reg(msr_pkg::CFG_NUM_COLS, pad_field({10'd0, cols}, 6));
		write_reg(msr_pkg::CFG_SHELL_NUMBER, pad_field({11'd0, shell}, 5));
		write_reg(msr_pkg::CFG_ROTATE_BY, rot);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Drop valid, wait for every owed result, then let the core settle
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) tracker.check_transfer(out_data);
	end

	// Drive the result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int run_len;
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			run_len = $urandom_range(1, 12);
			out_ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// End a hung run
	initial begin : watchdog
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int          len, k, r, c, mind;
		logic [5:0]  rows, cols;
		logic [4:0]  shell;
		logic [15:0] rot;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Corners and extreme words under the reset setting, no rotation
		issue_write(0, 0, 32'h7FFF_FFFF);
		issue_write(31, 31, 32'h8000_0000);
		issue_write(0, 31, 32'hFFFF_FFFF);
		issue_write(31, 0, 32'h0000_0000);
		issue_write(7, 9, 32'h0000_0001);
		issue_read(0, 0);
		issue_read(31, 31);
		issue_read(0, 31);
		issue_read(31, 0);
		issue_read(7, 9);
		drain();

		// Largest rotation amount on the outer ring
		set_config(6'd32, 6'd32, 5'd1, 16'hFFFF);
		issue_read(0, 0);
		issue_read(31, 31);
		issue_read(0, 31);
		issue_read(31, 0);
		drain();

		// Oversized dimensions clamp; shell 16 is then the innermost 2x2 ring
		set_config(6'd63, 6'd63, 5'd16, 16'd1);
		issue_write(16, 15, 32'h1234_5678);
		issue_read(15, 15);
		issue_read(16, 16);
		issue_read(3, 3);
		drain();

		// Single row makes the shell degenerate; access outside the matrix in use
		set_config(6'd1, 6'd32, 5'd1, 16'd5);
		issue_read(0, 4);
		issue_write(20, 20, random_word());
		issue_read(20, 20);
		drain();

		// Shell zero over an empty matrix
		set_config(6'd0, 6'd0, 5'd0, 16'd7);
		issue_read(2, 2);
		drain();

		// Shell beyond the matrix
		set_config(6'd8, 6'd8, 5'd31, 16'd3);
		issue_read(7, 7);
		drain();

		// Random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_config(6'd32, 6'd32, 5'd1, 16'($urandom()));
				1: set_config(6'd2, 6'd2, 5'd1, 16'($urandom()));
				2: set_config(6'd32, 6'd2, 5'd1, 16'hFFFF);
				3: set_config(6'd2, 6'd32, 5'd1, 16'($urandom()));
				4: set_config(6'd63, 6'd40, 5'd16, 16'($urandom()));
				5: set_config(6'd31, 6'd31, 5'd16, 16'($urandom()));
				default: begin
					rows = pick_dim();
					cols = pick_dim();
					mind = (rows > DIM) ? DIM : rows;
					if (((cols > DIM) ? DIM : cols) < mind) mind = (cols > DIM) ? DIM : cols;
					if ($urandom_range(0, 99) < 80)
						shell = 5'($urandom_range(1, (mind / 2 < 1) ? 1 : mind / 2));
					else
						shell = 5'($urandom_range(0, 31));
					if ($urandom_range(0, 1) == 0)
						rot = 16'($urandom_range(0, 4 * mind + 4));
					else
						rot = 16'($urandom());
					set_config(rows, cols, shell, rot);
				end
			endcase
			calm     = (p == 3);
			hold_off = (p == 6);
			// Aim most accesses at the selected ring, the rest anywhere in the store
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				len = tracker.ring_len();
				if (len > 0 && $urandom_range(0, 99) < 60) begin
					k = $urandom_range(0, len - 1);
					tracker.ring_pos(k, r, c);
				end else begin
					r = $urandom_range(0, 31);
					c = $urandom_range(0, 31);
				end
				if ($urandom_range(0, 99) < 35) issue_write(r, c, random_word());
				else issue_read(r, c);
			end
			drain();
		end
		calm = 1'b0;

		$display("Covered %0d transfers over %0d register settings, %0d rotated ring reads.",
			sent, settings, tracker.ring_reads);
		$display("%0d results flagged an invalid shell; %0d mismatches in %0d cycles.",
			tracker.flagged, tracker.errors, cycles);
		if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
